// ===== sv/ipru_pkg.sv =====
// Shared types and constants for the integer pixel replication upscaler.
// No dependencies; the top level, control stage and emitter import this package.
`default_nettype none

package ipru_pkg;

  localparam int CfgW       = 11;  // config write data, widest register
  localparam int SrcWidthW  = 11;  // source_width register
  localparam int MagW       = 5;   // magnify_factor register
  localparam int OutColW    = 14;  // out_column field
  localparam int RepW       = 4;   // replays_left counter
  localparam int PixW       = 24;  // packed RGB pixel

  localparam logic [SrcWidthW-1:0] SrcWidthRst = 11'd640;
  localparam logic [MagW-1:0]      MagRst      = 5'd2;

  typedef enum logic {
    CFG_SOURCE_WIDTH   = 1'b0,
    CFG_MAGNIFY_FACTOR = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    REQ_PIXEL  = 1'b0,
    REQ_REPLAY = 1'b1
  } req_e;

  typedef enum logic {
    STATUS_OK          = 1'b0,
    STATUS_IDLE_REPLAY = 1'b1
  } status_e;

  typedef enum logic [1:0] {
    JOB_PIXEL  = 2'd0,
    JOB_REPLAY = 2'd1,
    JOB_IDLE   = 2'd2
  } job_e;

  typedef struct packed {
    req_e       req_type;
    logic [7:0] in_red;
    logic [7:0] in_green;
    logic [7:0] in_blue;
  } pix_req_t;

  typedef struct packed {
    logic [7:0]         out_red;
    logic [7:0]         out_green;
    logic [7:0]         out_blue;
    logic [OutColW-1:0] out_column;
    logic               line_end;
    logic               run_last;
    status_e            status;
  } pix_res_t;

  // One decoded run handed from the control stage to the emitter.
  typedef struct packed {
    job_e               kind;
    logic [PixW-1:0]    pix;       // source pixel, pixel jobs only
    logic [OutColW-1:0] base_col;  // source column * factor
    logic               last_col;  // run closes the output line
  } job_t;

endpackage

`default_nettype wire

// ===== sv/ipru_stream_if.sv =====
// Valid/ready stream channel carrying one payload struct per transaction.
// Payload type is a parameter; the block uses the ipru_pkg structs.
`default_nettype none

interface ipru_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== sv/integer_pixel_replication_upscaler.sv =====
// Integer pixel replication upscaler, top level.
// Order: the first result of an item is valid once it has passed the job
//   register and the emitter register; a busy emitter can hold it in between.
// Rate: one result per cycle while res_o.ready is high. An item holds the
//   emitter for factor results (one for an idle replay); the next item is buffered.
// Reset: counters cleared, source_width 640, magnify_factor 2; the line store
//   is not cleared and needs no clearing pass.
`default_nettype none

module integer_pixel_replication_upscaler #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_MAGNIFY = 16
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire ipru_pkg::cfg_idx_e        cfg_idx_i,
  input  wire logic [ipru_pkg::CfgW-1:0] cfg_wdata_i,
  ipru_stream_if.sink                    pix_i,
  ipru_stream_if.source                  res_o
);

  import ipru_pkg::*;

  localparam int ColW  = $clog2(MAX_WIDTH + 1);
  localparam int FacW  = $clog2(MAX_MAGNIFY + 1);
  localparam int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  // Control stage -> emitter. The job register sits between the line store
  // access and the emitter, so a replay's read data is ready when the job is.
  job_t             job;
  logic [FacW-1:0]  job_fac;
  logic             job_valid;
  logic             job_take;

  // Line store port. One transaction per cycle means one access per cycle:
  // pixels write, replays read. A read's data is held until the next read,
  // which cannot come before the emitter has taken the job that needs it.
  logic             ram_en;
  logic             ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [PixW-1:0]  ram_wdata;
  logic [PixW-1:0]  ram_rdata;

  ipru_ctrl #(
    .MAX_WIDTH   (MAX_WIDTH),
    .MAX_MAGNIFY (MAX_MAGNIFY),
    .ColW        (ColW),
    .FacW        (FacW),
    .AddrW       (AddrW)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_i       (pix_i),
    .job_o       (job),
    .job_fac_o   (job_fac),
    .job_valid_o (job_valid),
    .job_take_i  (job_take),
    .ram_en_o    (ram_en),
    .ram_we_o    (ram_we),
    .ram_addr_o  (ram_addr),
    .ram_wdata_o (ram_wdata)
  );

  // One source row of RGB pixels.
  ipru_ram #(
    .Width (PixW),
    .Depth (MAX_WIDTH),
    .AddrW (AddrW)
  ) u_line_store (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  // Emitter doubles as the output register; it takes the next job in the
  // same cycle its last result is taken.
  ipru_emit #(
    .MAX_MAGNIFY (MAX_MAGNIFY),
    .FacW        (FacW)
  ) u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_i       (job),
    .job_fac_i   (job_fac),
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .ram_rdata_i (ram_rdata),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

// ===== sv/ipru_ram.sv =====
// Generic single-port synchronous RAM, registered read, no reset.
// No dependencies.
`default_nettype none

module ipru_ram #(
  parameter int Width = 24,
  parameter int Depth = 1024,
  parameter int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             en_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] addr_i,
  input  wire logic [Width-1:0] wdata_i,
  output logic      [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== sv/ipru_ctrl.sv =====
// Control stage: config registers, row/replay counters, line store access
// and the job register feeding the emitter. Depends on ipru_pkg, ipru_stream_if.
`default_nettype none

module ipru_ctrl #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_MAGNIFY = 16,
  parameter int ColW  = $clog2(MAX_WIDTH + 1),
  parameter int FacW  = $clog2(MAX_MAGNIFY + 1),
  parameter int AddrW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     cfg_we_i,
  input  wire ipru_pkg::cfg_idx_e       cfg_idx_i,
  input  wire logic [ipru_pkg::CfgW-1:0] cfg_wdata_i,
  ipru_stream_if.sink                   pix_i,
  output ipru_pkg::job_t                job_o,
  output logic      [FacW-1:0]          job_fac_o,
  output logic                          job_valid_o,
  input  wire logic                     job_take_i,
  output logic                          ram_en_o,
  output logic                          ram_we_o,
  output logic      [AddrW-1:0]         ram_addr_o,
  output logic      [ipru_pkg::PixW-1:0] ram_wdata_o
);

  import ipru_pkg::*;

  localparam int ProdW = ColW + FacW + OutColW;

  logic [SrcWidthW-1:0] src_width_q, src_width_d;
  logic [MagW-1:0]      mag_q, mag_d;
  logic [ColW-1:0]      load_col_q, load_col_d;
  logic [ColW-1:0]      rep_col_q, rep_col_d;
  logic [RepW-1:0]      reps_left_q, reps_left_d;

  logic                 jv_q, jv_d;
  job_e                 jkind_q, jkind_d;
  logic [PixW-1:0]      jpix_q, jpix_d;
  logic [ColW-1:0]      jcol_q, jcol_d;
  logic                 jlast_q, jlast_d;
  logic [FacW-1:0]      jfac_q, jfac_d;

  logic [ColW-1:0]      width;
  logic [FacW-1:0]      fac;
  logic [ColW-1:0]      lc;
  logic [ColW-1:0]      col_sel;
  logic [ColW-1:0]      col_inc;
  logic                 acc;
  logic [PixW-1:0]      in_pix;
  logic [ProdW-1:0]     prod;

  // clamp registers to their usable range
  always_comb begin
    if (src_width_q == '0) begin
      width = ColW'(1);
    end else if (32'(src_width_q) > 32'(MAX_WIDTH)) begin
      width = ColW'(MAX_WIDTH);
    end else begin
      width = ColW'(src_width_q);
    end
    if (mag_q == '0) begin
      fac = FacW'(1);
    end else if (32'(mag_q) > 32'(MAX_MAGNIFY)) begin
      fac = FacW'(MAX_MAGNIFY);
    end else begin
      fac = FacW'(mag_q);
    end
  end

  assign pix_i.ready = ~jv_q | job_take_i;
  assign acc         = pix_i.valid & pix_i.ready;
  assign in_pix      = {pix_i.data.in_red, pix_i.data.in_green, pix_i.data.in_blue};

  always_comb begin
    src_width_d = src_width_q;
    mag_d       = mag_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SOURCE_WIDTH:   src_width_d = cfg_wdata_i[SrcWidthW-1:0];
        CFG_MAGNIFY_FACTOR: mag_d       = cfg_wdata_i[MagW-1:0];
      endcase
    end
  end

  always_comb begin
    load_col_d  = load_col_q;
    rep_col_d   = rep_col_q;
    reps_left_d = reps_left_q;
    jv_d        = jv_q & ~job_take_i;
    jkind_d     = jkind_q;
    jpix_d      = jpix_q;
    jcol_d      = jcol_q;
    jlast_d     = jlast_q;
    jfac_d      = jfac_q;
    ram_en_o    = 1'b0;
    ram_we_o    = 1'b0;
    ram_wdata_o = in_pix;

    // pending replays are dropped by a new pixel; stale column restarts row
    lc = (reps_left_q != '0) ? '0 : load_col_q;
    if (lc >= width) begin
      lc = '0;
    end
    col_sel = (pix_i.data.req_type == REQ_PIXEL) ? lc : rep_col_q;
    col_inc = col_sel + ColW'(1);
    ram_addr_o = col_sel[AddrW-1:0];

    if (acc) begin
      jv_d    = 1'b1;
      jpix_d  = in_pix;
      jcol_d  = col_sel;
      jlast_d = (col_inc >= width);
      jfac_d  = fac;
      if (pix_i.data.req_type == REQ_PIXEL) begin
        jkind_d  = JOB_PIXEL;
        ram_en_o = 1'b1;
        ram_we_o = 1'b1;
        if (col_inc >= width) begin
          load_col_d  = '0;
          rep_col_d   = '0;
          reps_left_d = RepW'(fac - FacW'(1));
        end else begin
          load_col_d  = col_inc;
          rep_col_d   = (reps_left_q != '0) ? '0 : rep_col_q;
          reps_left_d = '0;
        end
      end else if (reps_left_q == '0) begin
        jkind_d = JOB_IDLE;
      end else begin
        jkind_d  = JOB_REPLAY;
        ram_en_o = 1'b1;
        if (col_inc >= width) begin
          rep_col_d   = '0;
          reps_left_d = reps_left_q - RepW'(1);
        end else begin
          rep_col_d   = col_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_width_q <= SrcWidthRst;
      mag_q       <= MagRst;
      load_col_q  <= '0;
      rep_col_q   <= '0;
      reps_left_q <= '0;
      jv_q        <= 1'b0;
    end else begin
      src_width_q <= src_width_d;
      mag_q       <= mag_d;
      load_col_q  <= load_col_d;
      rep_col_q   <= rep_col_d;
      reps_left_q <= reps_left_d;
      jv_q        <= jv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    jkind_q <= jkind_d;
    jpix_q  <= jpix_d;
    jcol_q  <= jcol_d;
    jlast_q <= jlast_d;
    jfac_q  <= jfac_d;
  end

  // start column of the run in the magnified line
  assign prod = ProdW'(jcol_q) * ProdW'(jfac_q);

  assign job_o.kind     = jkind_q;
  assign job_o.pix      = jpix_q;
  assign job_o.base_col = prod[OutColW-1:0];
  assign job_o.last_col = jlast_q;
  assign job_fac_o      = jfac_q;
  assign job_valid_o    = jv_q;

endmodule

`default_nettype wire

// ===== sv/ipru_emit.sv =====
// Emitter: repeats one pixel factor times (once for an idle replay) into the registered result channel.
// Depends on ipru_pkg and ipru_stream_if.
`default_nettype none

module ipru_emit #(
  parameter int MAX_MAGNIFY = 16,
  parameter int FacW = $clog2(MAX_MAGNIFY + 1)
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire ipru_pkg::job_t            job_i,
  input  wire logic      [FacW-1:0]      job_fac_i,
  input  wire logic                      job_valid_i,
  output logic                           job_take_o,
  input  wire logic [ipru_pkg::PixW-1:0] ram_rdata_i,
  ipru_stream_if.source                  res_o
);

  import ipru_pkg::*;

  logic               busy_q, busy_d;
  job_e               kind_q, kind_d;
  logic [PixW-1:0]    pix_q, pix_d;
  logic [OutColW-1:0] col_q, col_d;
  logic               last_col_q, last_col_d;
  logic [FacW-1:0]    rem_q, rem_d;
  logic               last;
  logic               fire;

  assign last       = (rem_q == '0);
  assign fire       = busy_q & res_o.ready;
  assign job_take_o = job_valid_i & (~busy_q | (fire & last));

  always_comb begin
    busy_d     = busy_q;
    kind_d     = kind_q;
    pix_d      = pix_q;
    col_d      = col_q;
    last_col_d = last_col_q;
    rem_d      = rem_q;
    if (job_take_o) begin
      busy_d     = 1'b1;
      kind_d     = job_i.kind;
      col_d      = job_i.base_col;
      last_col_d = job_i.last_col;
      rem_d      = job_fac_i - FacW'(1);
      unique case (job_i.kind)
        JOB_PIXEL:  pix_d = job_i.pix;
        JOB_REPLAY: pix_d = ram_rdata_i;
        default: begin
          pix_d      = '0;
          col_d      = '0;
          last_col_d = 1'b0;
          rem_d      = '0;
        end
      endcase
    end else if (fire) begin
      if (last) begin
        busy_d = 1'b0;
      end else begin
        rem_d = rem_q - FacW'(1);
        col_d = col_q + OutColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
    end
  end

  always_ff @(posedge clk_i) begin
    kind_q     <= kind_d;
    pix_q      <= pix_d;
    col_q      <= col_d;
    last_col_q <= last_col_d;
    rem_q      <= rem_d;
  end

  always_comb begin
    res_o.valid           = busy_q;
    res_o.data.out_red    = pix_q[23:16];
    res_o.data.out_green  = pix_q[15:8];
    res_o.data.out_blue   = pix_q[7:0];
    res_o.data.out_column = col_q;
    res_o.data.line_end   = last & last_col_q;
    res_o.data.run_last   = last;
    res_o.data.status     = (kind_q == JOB_IDLE) ? STATUS_IDLE_REPLAY : STATUS_OK;
  end

endmodule

`default_nettype wire
